// ----- sv/dprr_pkg.sv -----
// shared types, constants and helpers for the debug packet request/response rings
package dprr_pkg;

    // ring geometry
    localparam int PACKET_COUNT = 4;
    localparam int PACKET_SIZE  = 64;
    localparam int SLOT_W       = $clog2(PACKET_COUNT);
    localparam int OFF_W        = $clog2(PACKET_SIZE);
    localparam int ADDR_W       = SLOT_W + OFF_W;
    localparam int MEM_DEPTH    = PACKET_COUNT * (2 ** OFF_W);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_FULL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_OP  = 2'd1;

    localparam logic [BYTE_W-1:0] ABORT_OP_RESET = 8'd7;

    // input beat modes
    typedef enum logic [1:0] {
        MODE_HOST_OUT = 2'd0,
        MODE_FETCH    = 2'd1,
        MODE_RESP     = 2'd2,
        MODE_IN_DONE  = 2'd3
    } t_mode;

    // result destinations
    typedef enum logic [1:0] {
        TGT_REQ   = 2'd0,
        TGT_RESP  = 2'd1,
        TGT_ABORT = 2'd2
    } t_target;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        target;
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic [LEN_W-1:0]  packet_length;
    } t_out_beat;

    // slot index with wrap
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(PACKET_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// ----- sv/debug_packet_request_response_rings.sv -----
// Request and response packet rings between a USB endpoint and a debug command engine.
// Host OUT bytes (mode 0) fill the request ring, the engine fetches the oldest request
// (mode 1) and returns response bytes (mode 2), and IN completion (mode 3) sends the
// next queued response. Both rings live in 256 x 8 synchronous memories with registered
// read data; the block handles one input beat at a time. A beat that emits nothing, or
// only an abort pulse, leaves the block idle. A beat that emits a packet enters the
// emit state: packet bytes stream from the memory read port at one per cycle while the
// output is not stalled, and the block returns to idle after the last byte is taken.
// Inputs are stalled while a packet streams out. Configuration writes are taken at any time.
module debug_packet_request_response_rings
    import dprr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // configuration
    logic              r_send_full;
    logic [BYTE_W-1:0] r_abort_op;

    // ring control
    logic [SLOT_W-1:0] r_req_in, n_req_in, r_req_out, n_req_out;
    logic              r_req_full, n_req_full, r_req_drop, n_req_drop;
    logic [LEN_W-1:0]  r_req_cnt, n_req_cnt;
    logic [SLOT_W-1:0] r_resp_in, n_resp_in, r_resp_out, n_resp_out;
    logic              r_resp_full, n_resp_full, r_in_idle, n_in_idle;
    logic [LEN_W-1:0]  r_resp_cnt, n_resp_cnt;

    // per-slot lengths
    logic [LEN_W-1:0]  r_req_len  [PACKET_COUNT];
    logic [LEN_W-1:0]  r_resp_len [PACKET_COUNT];

    // emission and output
    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_target, n_target;
    logic              r_out_last, n_out_last;
    logic              r_pad, n_pad;
    logic [BYTE_W-1:0] r_abort_byte, n_abort_byte;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LEN_W-1:0]  r_idx, n_idx, r_len, n_len, r_total, n_total;

    // memories
    logic [BYTE_W-1:0] r_req_mem  [MEM_DEPTH];
    logic [BYTE_W-1:0] r_resp_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_req_rd, r_resp_rd;
    logic [ADDR_W-1:0] rd_addr;

    // beat decode
    logic              in_take, out_take;
    logic              req_avail, resp_avail;
    logic              req_first, req_drop_eff, req_store, req_len_we;
    logic [LEN_W-1:0]  req_cnt_new;
    logic              resp_accept, resp_store, resp_len_we;
    logic [LEN_W-1:0]  resp_cnt_new;
    logic              start;
    logic [1:0]        st_target;
    logic [SLOT_W-1:0] st_slot;
    logic [LEN_W-1:0]  st_len, st_total, idx_inc;

    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    assign req_avail  = (r_req_in != r_req_out) || r_req_full;
    assign resp_avail = (r_resp_in != r_resp_out) || r_resp_full;

    // host packet bookkeeping
    assign req_first    = (r_req_cnt == '0) && !r_req_drop;
    assign req_drop_eff = r_req_drop ||
                          (req_first && ((i_in.data_byte == r_abort_op) || r_req_full));
    assign req_store    = in_take && (i_in.mode == MODE_HOST_OUT) && !req_drop_eff &&
                          (r_req_cnt < LEN_W'(PACKET_SIZE));
    assign req_cnt_new  = r_req_cnt + LEN_W'(req_store);
    assign req_len_we   = in_take && (i_in.mode == MODE_HOST_OUT) && i_in.byte_last &&
                          !req_drop_eff;

    // response bookkeeping
    assign resp_accept  = in_take && (i_in.mode == MODE_RESP) && req_avail && !r_resp_full;
    assign resp_store   = resp_accept && (r_resp_cnt < LEN_W'(PACKET_SIZE));
    assign resp_cnt_new = r_resp_cnt + LEN_W'(resp_store);
    assign resp_len_we  = resp_accept && i_in.byte_last;

    assign idx_inc = r_idx + 1'b1;
    assign rd_addr = {n_slot, n_idx[OFF_W-1:0]};

    // next-state logic
    always_comb begin
        n_req_in     = r_req_in;
        n_req_out    = r_req_out;
        n_req_full   = r_req_full;
        n_req_drop   = r_req_drop;
        n_req_cnt    = r_req_cnt;
        n_resp_in    = r_resp_in;
        n_resp_out   = r_resp_out;
        n_resp_full  = r_resp_full;
        n_resp_cnt   = r_resp_cnt;
        n_in_idle    = r_in_idle;
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_target     = r_target;
        n_out_last   = r_out_last;
        n_pad        = r_pad;
        n_abort_byte = r_abort_byte;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_len        = r_len;
        n_total      = r_total;
        start        = 1'b0;
        st_target    = TGT_REQ;
        st_slot      = r_req_out;
        st_len       = r_req_len[r_req_out];
        st_total     = r_req_len[r_req_out];

        case (r_state)
            ST_IDLE: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                end
                if (in_take) begin
                    case (i_in.mode)
                        MODE_HOST_OUT: begin
                            if (req_first && (i_in.data_byte == r_abort_op)) begin
                                n_out_valid  = 1'b1;
                                n_target     = TGT_ABORT;
                                n_abort_byte = i_in.data_byte;
                                n_out_last   = 1'b1;
                                n_total      = '0;
                            end
                            if (i_in.byte_last) begin
                                if (!req_drop_eff) begin
                                    n_req_in   = next_slot(r_req_in);
                                    n_req_full = (next_slot(r_req_in) == r_req_out);
                                end
                                n_req_cnt  = '0;
                                n_req_drop = 1'b0;
                            end else begin
                                n_req_cnt  = req_cnt_new;
                                n_req_drop = req_drop_eff;
                            end
                        end
                        MODE_FETCH: begin
                            start = req_avail;
                        end
                        MODE_RESP: begin
                            if (resp_accept) begin
                                n_resp_cnt = resp_cnt_new;
                                if (i_in.byte_last) begin
                                    n_resp_cnt = '0;
                                    n_req_out  = next_slot(r_req_out);
                                    n_req_full = 1'b0;
                                    if (r_in_idle) begin
                                        n_in_idle = 1'b0;
                                        start     = 1'b1;
                                        st_target = TGT_RESP;
                                        st_slot   = r_resp_in;
                                        st_len    = resp_cnt_new;
                                        st_total  = r_send_full ? LEN_W'(PACKET_SIZE)
                                                                : resp_cnt_new;
                                    end else begin
                                        n_resp_in   = next_slot(r_resp_in);
                                        n_resp_full = (next_slot(r_resp_in) == r_resp_out);
                                    end
                                end
                            end
                        end
                        MODE_IN_DONE: begin
                            if (resp_avail) begin
                                start       = 1'b1;
                                st_target   = TGT_RESP;
                                st_slot     = r_resp_out;
                                st_len      = r_resp_len[r_resp_out];
                                st_total    = r_send_full ? LEN_W'(PACKET_SIZE)
                                                          : r_resp_len[r_resp_out];
                                n_resp_out  = next_slot(r_resp_out);
                                n_resp_full = 1'b0;
                            end else begin
                                n_in_idle = 1'b1;
                            end
                        end
                        default: begin
                            n_in_idle = r_in_idle;
                        end
                    endcase
                end
                // packet start: first byte is read this cycle
                if (start) begin
                    n_state     = ST_EMIT;
                    n_out_valid = 1'b1;
                    n_target    = st_target;
                    n_slot      = st_slot;
                    n_idx       = '0;
                    n_len       = st_len;
                    n_total     = st_total;
                    n_out_last  = (st_total == LEN_W'(1));
                    n_pad       = (st_len == '0);
                end
            end
            ST_EMIT: begin
                if (out_take) begin
                    if (r_out_last) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b0;
                    end else begin
                        n_idx      = idx_inc;
                        n_out_last = ((idx_inc + 1'b1) == r_total);
                        n_pad      = (idx_inc >= r_len);
                    end
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_full <= 1'b0;
            r_abort_op  <= ABORT_OP_RESET;
            r_req_in    <= '0;
            r_req_out   <= '0;
            r_req_full  <= 1'b0;
            r_req_drop  <= 1'b0;
            r_req_cnt   <= '0;
            r_resp_in   <= '0;
            r_resp_out  <= '0;
            r_resp_full <= 1'b0;
            r_resp_cnt  <= '0;
            r_in_idle   <= 1'b1;
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEND_FULL: r_send_full <= i_cfg_data[0];
                    CFG_ABORT_OP:  r_abort_op  <= i_cfg_data;
                    default:       r_send_full <= r_send_full;
                endcase
            end
            r_req_in    <= n_req_in;
            r_req_out   <= n_req_out;
            r_req_full  <= n_req_full;
            r_req_drop  <= n_req_drop;
            r_req_cnt   <= n_req_cnt;
            r_resp_in   <= n_resp_in;
            r_resp_out  <= n_resp_out;
            r_resp_full <= n_resp_full;
            r_resp_cnt  <= n_resp_cnt;
            r_in_idle   <= n_in_idle;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // output and emission payload
    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_out_last   <= n_out_last;
        r_pad        <= n_pad;
        r_abort_byte <= n_abort_byte;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_len        <= n_len;
        r_total      <= n_total;
        if (req_len_we) begin
            r_req_len[r_req_in] <= req_cnt_new;
        end
        if (resp_len_we) begin
            r_resp_len[r_resp_in] <= resp_cnt_new;
        end
    end

    // request ring memory
    always_ff @(posedge i_clk) begin
        if (req_store) begin
            r_req_mem[{r_req_in, r_req_cnt[OFF_W-1:0]}] <= i_in.data_byte;
        end
        r_req_rd <= r_req_mem[rd_addr];
    end

    // response ring memory, write forwarded to a same-address read
    always_ff @(posedge i_clk) begin
        if (resp_store) begin
            r_resp_mem[{r_resp_in, r_resp_cnt[OFF_W-1:0]}] <= i_in.data_byte;
        end
        if (resp_store && ({r_resp_in, r_resp_cnt[OFF_W-1:0]} == rd_addr)) begin
            r_resp_rd <= i_in.data_byte;
        end else begin
            r_resp_rd <= r_resp_mem[rd_addr];
        end
    end

    // result beat
    always_comb begin
        o_out.target        = r_target;
        o_out.out_last      = r_out_last;
        o_out.packet_length = r_total;
        case (r_target)
            TGT_REQ:   o_out.out_byte = r_req_rd;
            TGT_RESP:  o_out.out_byte = r_pad ? '0 : r_resp_rd;
            TGT_ABORT: o_out.out_byte = r_abort_byte;
            default:   o_out.out_byte = '0;
        endcase
    end

`ifndef SYNTH
    // a full ring has met indices
    a_req_full_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_full |-> (r_req_in == r_req_out))
        else $error("request ring full with differing indices");

    a_resp_full_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resp_full |-> (r_resp_in == r_resp_out))
        else $error("response ring full with differing indices");

    // while streaming a beat is always presented and inside the packet
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_out_valid && (r_idx < r_total)))
        else $error("emission without a valid beat in range");

    // a taken final byte ends the emission
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && out_take && r_out_last) |=> (r_state == ST_IDLE))
        else $error("emission did not end after final byte");
`endif

endmodule

// ----- tb/debug_packet_request_response_rings_tb.sv -----
// testbench for the debug packet request/response rings: queued stimulus, ring predictor, checker
`timescale 1ns / 1ps

module debug_packet_request_response_rings_tb;
    import dprr_pkg::*;

    localparam int SETTLE_CYC = 4;
    localparam int TAIL_CYC   = 100;
    localparam int STALL_MAX  = 6;

    // stimulus queue entries: an input beat, a register write, or a pause until drained
    typedef enum {ACT_BEAT, ACT_CFG, ACT_DRAIN} t_stim_kind;

    typedef struct {
        t_stim_kind            kind;
        t_in_beat              beat;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [BYTE_W-1:0]     reg_val;
    } t_stim;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;

    t_stim     pending_q[$];
    t_out_beat out_beats_due[$];
    int        beats_queued = 0;
    int        mismatches   = 0;

    // predicted ring state
    logic [BYTE_W-1:0] req_mem [PACKET_COUNT][PACKET_SIZE];
    logic [LEN_W-1:0]  req_len [PACKET_COUNT];
    logic [SLOT_W-1:0] req_wr   = '0;
    logic [SLOT_W-1:0] req_rd   = '0;
    bit                req_full = 1'b0;
    int unsigned       req_cnt  = 0;
    bit                req_drop = 1'b0;
    logic [BYTE_W-1:0] rsp_mem [PACKET_COUNT][PACKET_SIZE];
    logic [LEN_W-1:0]  rsp_len [PACKET_COUNT];
    logic [SLOT_W-1:0] rsp_wr   = '0;
    logic [SLOT_W-1:0] rsp_rd   = '0;
    bit                rsp_full = 1'b0;
    int unsigned       rsp_cnt  = 0;
    bit                in_idle  = 1'b1;
    bit                cfg_send_full = 1'b0;
    logic [BYTE_W-1:0] cfg_abort_op  = ABORT_OP_RESET;

    debug_packet_request_response_rings i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // slot index with wrap round the ring
    function automatic logic [SLOT_W-1:0] ring_step(input logic [SLOT_W-1:0] s);
        return (int'(s) + 1 == PACKET_COUNT) ? '0 : SLOT_W'(int'(s) + 1);
    endfunction

    function automatic void push_due(input t_target tgt, input logic [BYTE_W-1:0] b,
                                     input logic l, input int unsigned n);
        t_out_beat ob;
        ob.target        = tgt;
        ob.out_byte      = b;
        ob.out_last      = l;
        ob.packet_length = LEN_W'(n);
        out_beats_due.push_back(ob);
    endfunction

    // response slot to the IN endpoint, padded to full size when asked
    function automatic void send_in_packet(input logic [SLOT_W-1:0] slot);
        int unsigned len;
        int unsigned total;
        len   = 32'(rsp_len[slot]);
        total = cfg_send_full ? PACKET_SIZE : len;
        for (int unsigned i = 0; i < total; i++) begin
            push_due(TGT_RESP, (i < len) ? rsp_mem[slot][i] : '0, i + 1 == total, total);
        end
    endfunction

    // advance the ring state by one accepted input beat and queue the beats it causes
    function automatic void rings_apply_beat(input t_in_beat b);
        int unsigned len;
        bit          have_req;
        have_req = (req_wr != req_rd) || req_full;
        case (t_mode'(b.mode))
            MODE_HOST_OUT: begin
                // abort opcode wins over a full ring
                if (req_cnt == 0 && !req_drop) begin
                    if (b.data_byte == cfg_abort_op) begin
                        push_due(TGT_ABORT, b.data_byte, 1'b1, 0);
                        req_drop = 1'b1;
                    end else if (req_full) begin
                        req_drop = 1'b1;
                    end
                end
                if (!req_drop && req_cnt < PACKET_SIZE) begin
                    req_mem[req_wr][req_cnt] = b.data_byte;
                    req_cnt++;
                end
                if (b.byte_last) begin
                    if (!req_drop) begin
                        req_len[req_wr] = LEN_W'(req_cnt);
                        req_wr = ring_step(req_wr);
                        if (req_wr == req_rd) req_full = 1'b1;
                    end
                    req_cnt  = 0;
                    req_drop = 1'b0;
                end
            end
            MODE_FETCH: begin
                // oldest request, not retired
                if (have_req) begin
                    len = 32'(req_len[req_rd]);
                    for (int unsigned i = 0; i < len; i++) begin
                        push_due(TGT_REQ, req_mem[req_rd][i], i + 1 == len, len);
                    end
                end
            end
            MODE_RESP: begin
                if (have_req && !rsp_full) begin
                    if (rsp_cnt < PACKET_SIZE) begin
                        rsp_mem[rsp_wr][rsp_cnt] = b.data_byte;
                        rsp_cnt++;
                    end
                    if (b.byte_last) begin
                        rsp_len[rsp_wr] = LEN_W'(rsp_cnt);
                        rsp_cnt  = 0;
                        req_rd   = ring_step(req_rd);
                        req_full = 1'b0;
                        if (in_idle) begin
                            in_idle = 1'b0;
                            send_in_packet(rsp_wr);
                        end else begin
                            rsp_wr = ring_step(rsp_wr);
                            if (rsp_wr == rsp_rd) rsp_full = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (rsp_wr != rsp_rd || rsp_full) begin
                    send_in_packet(rsp_rd);
                    rsp_rd   = ring_step(rsp_rd);
                    rsp_full = 1'b0;
                end else begin
                    in_idle = 1'b1;
                end
            end
        endcase
    endfunction

    // stimulus builders
    function automatic void add_beat(input t_mode m, input logic [BYTE_W-1:0] d,
                                     input logic l);
        t_stim s;
        s.kind           = ACT_BEAT;
        s.beat.mode      = m;
        s.beat.data_byte = d;
        s.beat.byte_last = l;
        s.reg_idx        = '0;
        s.reg_val        = '0;
        pending_q.push_back(s);
        beats_queued++;
    endfunction

    function automatic void add_ctrl(input t_stim_kind k, input logic [CFG_IDX_W-1:0] idx,
                                     input logic [BYTE_W-1:0] val);
        t_stim s;
        s.kind    = k;
        s.beat    = '0;
        s.reg_idx = idx;
        s.reg_val = val;
        pending_q.push_back(s);
    endfunction

    function automatic void add_packet(input t_mode m, input logic [BYTE_W-1:0] first,
                                       input int len);
        add_beat(m, first, len == 1);
        for (int i = 1; i < len; i++) begin
            add_beat(m, BYTE_W'($urandom_range(255)), i == len - 1);
        end
    endfunction

    // mostly well-formed exchanges with short packets, a few oversized ones, some noise
    function automatic void add_random_traffic(input int beats, input logic [BYTE_W-1:0] abort_op);
        int target_cnt;
        int pick;
        int len;
        target_cnt = beats_queued + beats;
        while (beats_queued < target_cnt) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(19) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 5);
            if (pick < 45) begin
                add_packet(MODE_HOST_OUT,
                           ($urandom_range(9) == 0) ? abort_op : BYTE_W'($urandom_range(255)),
                           len);
            end else if (pick < 60) begin
                add_beat(MODE_FETCH, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 80) begin
                add_packet(MODE_RESP, BYTE_W'($urandom_range(255)), len);
            end else if (pick < 93) begin
                add_beat(MODE_IN_DONE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                add_beat(t_mode'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
        end
    endfunction

    function automatic bit field_matches(input string fname, input logic [BYTE_W-1:0] want,
                                         input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // driver: beats in bursts with gaps, register writes and pauses only once drained
    int burst_left = 1;
    int gap_left   = 0;
    int settle     = 0;

    always @(posedge i_clk) begin
        t_stim    front;
        logic     in_busy;
        logic     cfg_busy;
        logic     drive_beat;
        logic     drive_cfg;
        in_busy    = i_in_valid;
        cfg_busy   = i_cfg_valid;
        drive_beat = 1'b0;
        drive_cfg  = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                rings_apply_beat(i_in);
                in_busy = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEND_FULL: cfg_send_full = i_cfg_data[0];
                    CFG_ABORT_OP:  cfg_abort_op  = i_cfg_data;
                    default: ;
                endcase
                cfg_busy = 1'b0;
            end
            if (!in_busy && !cfg_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].kind == ACT_BEAT) begin
                        front      = pending_q.pop_front();
                        drive_beat = 1'b1;
                        i_in      <= front.beat;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else if ($urandom_range(3) == 0) begin
                            burst_left = $urandom_range(20, 50);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end else if (out_beats_due.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYC) begin
                        settle++;
                    end else begin
                        settle = 0;
                        front  = pending_q.pop_front();
                        if (front.kind == ACT_CFG) begin
                            drive_cfg    = 1'b1;
                            i_cfg_index <= front.reg_idx;
                            i_cfg_data  <= front.reg_val;
                        end
                    end
                end
            end
            if (!in_busy) i_in_valid <= drive_beat;
            if (!cfg_busy) i_cfg_valid <= drive_cfg;
        end
    end

    // monitor: check each result beat and stall in windows of varying density
    int stall_pct = 0;
    int stall_run = 0;
    int window    = 0;

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (out_beats_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %p",
                             $time, o_out);
                    mismatches++;
                end else begin
                    want = out_beats_due.pop_front();
                    if (!(field_matches("target", BYTE_W'(want.target),
                                        BYTE_W'(o_out.target))
                          & field_matches("out_byte", want.out_byte, o_out.out_byte)
                          & field_matches("out_last", BYTE_W'(want.out_last),
                                          BYTE_W'(o_out.out_last))
                          & field_matches("packet_length", BYTE_W'(want.packet_length),
                                          BYTE_W'(o_out.packet_length)))) begin
                        mismatches++;
                    end
                end
            end
            if (window == 0) begin
                window = 64;
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            window--;
            if (stall_run >= STALL_MAX || $urandom_range(99) >= stall_pct) begin
                stall_run = 0;
                i_out_stall <= 1'b0;
            end else begin
                stall_run++;
                i_out_stall <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus plan, reset and end of run
    initial begin
        logic [BYTE_W-1:0] abort_op;

        // directed: extremes, fetch, abort, retire, empty and full rings
        add_beat(MODE_HOST_OUT, 8'h00, 1'b0);
        add_beat(MODE_HOST_OUT, 8'hFF, 1'b1);
        add_beat(MODE_FETCH, 8'h00, 1'b0);
        add_beat(MODE_HOST_OUT, ABORT_OP_RESET, 1'b0);
        add_beat(MODE_HOST_OUT, 8'h55, 1'b0);
        add_beat(MODE_HOST_OUT, 8'h01, 1'b1);
        add_beat(MODE_RESP, 8'hAA, 1'b0);
        add_beat(MODE_RESP, 8'hFF, 1'b1);
        // fetch and response with no request waiting
        add_beat(MODE_FETCH, 8'hFF, 1'b1);
        add_beat(MODE_RESP, 8'h33, 1'b1);
        // IN done with nothing queued
        add_beat(MODE_IN_DONE, 8'h00, 1'b0);
        add_beat(MODE_IN_DONE, 8'hFF, 1'b1);
        // fill the request ring, then a packet that finds it full
        for (int i = 0; i < PACKET_COUNT; i++) add_beat(MODE_HOST_OUT, BYTE_W'(8'h10 + i), 1'b1);
        add_beat(MODE_HOST_OUT, 8'h11, 1'b0);
        add_beat(MODE_HOST_OUT, 8'h22, 1'b1);
        // abort opcode on a full ring
        add_beat(MODE_HOST_OUT, ABORT_OP_RESET, 1'b1);
        // first response goes straight out, the rest queue behind it
        for (int i = 0; i < PACKET_COUNT; i++) add_beat(MODE_RESP, BYTE_W'(8'h80 + i), 1'b1);
        for (int i = 0; i < PACKET_COUNT; i++) add_beat(MODE_IN_DONE, 8'h00, 1'b0);

        add_random_traffic(30, ABORT_OP_RESET);

        add_ctrl(ACT_CFG, CFG_SEND_FULL, 8'd1);
        add_ctrl(ACT_CFG, CFG_ABORT_OP, 8'd0);
        add_random_traffic(15, 8'd0);
        add_ctrl(ACT_DRAIN, '0, '0);
        add_random_traffic(15, 8'd0);

        add_ctrl(ACT_CFG, CFG_SEND_FULL, 8'd0);
        add_ctrl(ACT_CFG, CFG_ABORT_OP, 8'd255);
        add_random_traffic(30, 8'd255);

        abort_op = BYTE_W'($urandom_range(255));
        add_ctrl(ACT_CFG, CFG_SEND_FULL, 8'd1);
        add_ctrl(ACT_CFG, CFG_ABORT_OP, abort_op);
        add_random_traffic(30, abort_op);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || i_cfg_valid
               || out_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0 && out_beats_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
